[hdl/lsap_pkg.sv]
`timescale 1ns / 1ps
package lsap_pkg;
    localparam int Stages      = 6;
    localparam int SineEntries = 256;
    localparam int IdxW        = $clog2(SineEntries);
    localparam int StageW      = $clog2(Stages);
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 31;

    localparam logic [CfgIdxW-1:0] RegPhaseStep = 3'd0;
    localparam logic [CfgIdxW-1:0] RegFbGain    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegSweepLow  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegSweepHigh = 3'd3;
    localparam logic [CfgIdxW-1:0] RegDryGain   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegWetGain   = 3'd5;

    localparam logic signed [24:0] Max24 = 25'sd8388607;
    localparam logic signed [24:0] Min24 = -25'sd8388608;

    // Sine table entry k, Q1.15, integer quarter-wave polynomial
    function automatic logic signed [15:0] sine_rom(input logic [IdxW-1:0] k);
        logic [63:0] u, x, x2, t, s;
        logic [1:0]  quad;
        u = (64'(k) * 64'd65536) / SineEntries;
        quad = u[15:14];
        x = {50'd0, u[13:0]};
        if (quad[0]) x = 64'd16384 - x;
        x2 = (x * x) >> 14;
        t = (64'd5204 * x2) >> 14;
        t = 64'd42334 - t;
        t = (t * x2) >> 14;
        t = 64'd102944 - t;
        s = ((t * x) >> 14) >> 1;
        if (s > 64'd32767) s = 64'd32767;
        return quad[1] ? -16'(s) : 16'(s);
    endfunction
endpackage

[hdl/lfo_swept_allpass_phaser_unit.sv]
`timescale 1ns / 1ps
// Channel   | Ports                      | Payload
// input     | s_axis_tvalid/tready/tdata | sample_in[15:0]
// result    | m_axis_tvalid/tready/tdata | sample_out[15:0]
// config    | cfg_we/cfg_addr/cfg_wdata  | index 0..5 per register list
// Each sample passes from acceptance to result through the sweep value, the
// bit-serial divider for the allpass coefficient, then the feedback, stage and mix
// passes of the one shared 25x18 multiplier and its saturating adder.
// A new sample is taken only once the previous one has reached the output register.
// Reset is synchronous, active low, and clears control, LFO phase and filter memories.
// The result sits in an output register; the next sample may be taken meanwhile,
// and the sequencer waits at its last step while a previous result is still held.
module lfo_swept_allpass_phaser_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [15:0] sample_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // [15:0] sample_out
    input  logic                            cfg_we,
    input  logic [lsap_pkg::CfgIdxW-1:0]    cfg_addr,
    input  logic [lsap_pkg::CfgDataW-1:0]   cfg_wdata
);
    import lsap_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SINE, S_SWEEP, S_DIV, S_DIVW, S_FB, S_STY, S_STM,
        S_DRY, S_WET, S_OUT
    } state_t;

    state_t state_reg;
    logic [30:0] phase_step_reg;
    logic signed [15:0] fb_gain_reg, dry_gain_reg, wet_gain_reg;
    logic [15:0] sweep_low_reg, sweep_high_reg;
    logic [31:0] lfo_phase_reg;
    logic signed [23:0] mem_reg [Stages];
    logic signed [23:0] last_reg, x_reg, y_reg;
    logic signed [15:0] xin_reg, sine_reg;
    logic [16:0] d_reg, a_reg;
    logic [StageW-1:0] stg_reg;
    logic signed [40:0] acc_reg;
    logic [15:0] out_reg;
    logic out_valid_reg;

    // Shared multiplier operands
    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] prod;
    logic signed [42:0] rnd16, rnd15;
    logic signed [26:0] sum;
    logic signed [23:0] sum_sat;
    logic signed [17:0] span;
    logic signed [34:0] sweep_prod;
    logic signed [15:0] sine_tab [SineEntries];
    logic div_start, div_done;
    logic [16:0] div_q;

    // Constant sine table, one entry per LFO index
    for (genvar k = 0; k < SineEntries; k++) begin : g_sine
        assign sine_tab[k] = sine_rom(IdxW'(k));
    end

    always_comb begin
        mul_a = 25'(x_reg);
        mul_b = 18'(a_reg);
        case (state_reg)
            S_FB:    begin mul_a = 25'(last_reg); mul_b = 18'(fb_gain_reg); end
            S_STY:   begin mul_a = 25'(x_reg);    mul_b = 18'(a_reg);       end
            S_STM:   begin mul_a = 25'(y_reg);    mul_b = 18'(a_reg);       end
            S_DRY:   begin mul_a = 25'(xin_reg);  mul_b = 18'(dry_gain_reg); end
            S_WET:   begin mul_a = 25'(x_reg);    mul_b = 18'(wet_gain_reg); end
            default: begin mul_a = 25'(x_reg);    mul_b = 18'(a_reg);       end
        endcase
    end
    assign prod  = 43'(mul_a) * 43'(mul_b);
    assign rnd16 = (prod + 43'sd32768) >>> 16;
    assign rnd15 = (prod + 43'sd16384) >>> 15;

    // Saturating adder shared by chain input and stage updates
    always_comb begin
        case (state_reg)
            S_FB:    sum = 27'(xin_reg) + 27'(rnd15);
            S_STY:   sum = 27'(mem_reg[stg_reg]) - 27'(rnd16);
            default: sum = 27'(x_reg) + 27'(rnd16);
        endcase
        if (sum > 27'(Max24))      sum_sat = Max24[23:0];
        else if (sum < 27'(Min24)) sum_sat = Min24[23:0];
        else                       sum_sat = sum[23:0];
    end

    assign span = 18'(sweep_high_reg) - 18'(sweep_low_reg);
    assign sweep_prod = 35'(span) * (35'(sine_reg) + 35'sd32768);

    assign div_start = (state_reg == S_DIV);
    lsap_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num({(17'd65536 - d_reg), 16'd0} + 33'(17'd65536 + d_reg) / 2),
        .den(17'd65536 + d_reg), .done(div_done), .quot(div_q)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= 31'd8948;
            fb_gain_reg    <= 16'sd22938;
            sweep_low_reg  <= 16'd546;
            sweep_high_reg <= 16'd4642;
            dry_gain_reg   <= 16'sd22938;
            wet_gain_reg   <= 16'sd9830;
        end else if (cfg_we) begin
            case (cfg_addr)
                RegPhaseStep: phase_step_reg <= cfg_wdata;
                RegFbGain:    fb_gain_reg    <= cfg_wdata[15:0];
                RegSweepLow:  sweep_low_reg  <= cfg_wdata[15:0];
                RegSweepHigh: sweep_high_reg <= cfg_wdata[15:0];
                RegDryGain:   dry_gain_reg   <= cfg_wdata[15:0];
                RegWetGain:   wet_gain_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer: sweep, coefficient, feedback, six stages, mix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            lfo_phase_reg <= '0;
            last_reg      <= '0;
            for (int i = 0; i < Stages; i++) mem_reg[i] <= '0;
        end else begin
            if (out_valid_reg && m_axis_tready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    xin_reg   <= s_axis_tdata;
                    state_reg <= S_SINE;
                end
                S_SINE: begin
                    sine_reg      <= sine_tab[lfo_phase_reg[31 -: IdxW]];
                    lfo_phase_reg <= lfo_phase_reg + 32'(phase_step_reg);
                    state_reg     <= S_SWEEP;
                end
                S_SWEEP: begin
                    d_reg     <= 17'(18'(sweep_low_reg) + 18'(sweep_prod >>> 16));
                    state_reg <= S_DIV;
                end
                S_DIV: state_reg <= S_DIVW;
                S_DIVW: if (div_done) begin
                    a_reg     <= div_q;
                    state_reg <= S_FB;
                end
                S_FB: begin
                    x_reg     <= sum_sat;
                    stg_reg   <= '0;
                    state_reg <= S_STY;
                end
                S_STY: begin
                    y_reg     <= sum_sat;
                    state_reg <= S_STM;
                end
                S_STM: begin
                    mem_reg[stg_reg] <= sum_sat;
                    x_reg <= y_reg;
                    if (stg_reg == StageW'(Stages - 1)) begin
                        state_reg <= S_DRY;
                    end else begin
                        stg_reg   <= stg_reg + 1'b1;
                        state_reg <= S_STY;
                    end
                end
                S_DRY: begin
                    last_reg  <= x_reg;
                    acc_reg   <= 41'(prod);
                    state_reg <= S_WET;
                end
                S_WET: begin
                    acc_reg   <= (acc_reg + 41'(prod) + 41'sd16384) >>> 15;
                    state_reg <= S_OUT;
                end
                // Hold here while the previous result is still waiting
                S_OUT: if (!out_valid_reg || m_axis_tready) begin
                    if (acc_reg > 41'sd32767)       out_reg <= 16'h7FFF;
                    else if (acc_reg < -41'sd32768) out_reg <= 16'h8000;
                    else                            out_reg <= acc_reg[15:0];
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_coef_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FB) |-> (a_reg <= 17'd65536)) else $error("coef range");
    a_out_after_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT)) else $error("stray out");
endmodule

[hdl/lsap_div.sv]
`timescale 1ns / 1ps
// Restoring divider: 33-bit numerator by 17-bit divisor, one quotient bit a cycle
module lsap_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [16:0] den,
    output logic        done,
    output logic [16:0] quot
);
    logic [32:0] q_reg;
    logic [16:0] rem_reg;
    logic [16:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [17:0] trial;
    logic [18:0] diff;

    assign trial = {rem_reg, q_reg[32]};
    assign diff  = {1'b0, trial} - {2'b0, den_reg};
    assign quot  = q_reg[16:0];

    // Shift in one numerator bit and subtract when it fits
    always_ff @(posedge aclk) begin
        done <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            q_reg    <= num;
            rem_reg  <= '0;
            den_reg  <= den;
            cnt_reg  <= 6'd33;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            if (!diff[18]) begin
                rem_reg <= diff[16:0];
                q_reg   <= {q_reg[31:0], 1'b1};
            end else begin
                rem_reg <= trial[16:0];
                q_reg   <= {q_reg[31:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
                done     <= 1'b1;
            end
        end
    end
endmodule

[tb/sv/lsap_phaser_checker.sv]
`timescale 1ns / 1ps
module lsap_phaser_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [15:0]                   m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [lsap_pkg::CfgIdxW-1:0]  cfg_addr,
    input  logic [lsap_pkg::CfgDataW-1:0] cfg_wdata,
    output int                            samples_pending,
    output int                            mismatch_count,
    output int                            samples_checked
);
    import lsap_pkg::*;

    // Local copy of the register file
    logic [30:0]        lfo_step;
    logic signed [15:0] fb_gain;
    logic [15:0]        d_low;
    logic [15:0]        d_high;
    logic signed [15:0] dry_mult;
    logic signed [15:0] wet_mult;

    // Local copy of the filter state
    logic [31:0]        lfo_acc;
    longint             allpass_mem [Stages];
    longint             chain_prev;

    logic signed [15:0] mix_queue [$];

    function automatic longint clip24(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // Round to nearest, halves upward, then floor shift
    function automatic longint round_down_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    // Quarter-wave polynomial sine, Q1.15
    function automatic longint lfo_sine(input int k);
        longint u, q, x, x2, t, s;
        u = (longint'(k) * 65536) / SineEntries;
        q = (u >> 14) & 3;
        x = u & 16383;
        if (q[0]) x = 16384 - x;
        x2 = (x * x) >> 14;
        t = (5204 * x2) >> 14;
        t = 42334 - t;
        t = (t * x2) >> 14;
        t = 102944 - t;
        s = ((t * x) >> 14) >> 1;
        if (s > 32767) s = 32767;
        return q[1] ? -s : s;
    endfunction

    // Advance the sweep and the allpass chain by one sample; return the mix
    function automatic logic signed [15:0] phaser_mix(input logic signed [15:0] dry_in);
        longint w, d, a, x, y, m;
        int     k;
        k = int'((longint'(lfo_acc) * SineEntries) >> 32);
        w = lfo_sine(k) + 32768;
        d = longint'(d_low) + (((longint'(d_high) - longint'(d_low)) * w) >>> 16);
        lfo_acc = lfo_acc + {1'b0, lfo_step};
        a = (((65536 - d) << 16) + ((65536 + d) >> 1)) / (65536 + d);
        x = clip24(longint'(dry_in) + round_down_shift(chain_prev * longint'(fb_gain), 15));
        for (int i = 0; i < Stages; i++) begin
            y = clip24(allpass_mem[i] - round_down_shift(x * a, 16));
            allpass_mem[i] = clip24(x + round_down_shift(y * a, 16));
            x = y;
        end
        chain_prev = x;
        m = round_down_shift(longint'(dry_mult) * longint'(dry_in) +
                             longint'(wet_mult) * x, 15);
        if (m > 32767) m = 32767;
        if (m < -32768) m = -32768;
        return 16'(m);
    endfunction

    assign samples_pending = mix_queue.size();

    always @(posedge aclk) begin
        logic signed [15:0] want;
        if (!aresetn) begin
            lfo_step <= 31'd8948;
            fb_gain  <= 16'sd22938;
            d_low    <= 16'd546;
            d_high   <= 16'd4642;
            dry_mult <= 16'sd22938;
            wet_mult <= 16'sd9830;
            lfo_acc  = '0;
            chain_prev = 0;
            for (int i = 0; i < Stages; i++) allpass_mem[i] = 0;
            mix_queue.delete();
            mismatch_count  <= 0;
            samples_checked <= 0;
        end else begin
            // Apply register writes; unknown indexes drop out
            if (cfg_we) begin
                case (cfg_addr)
                    RegPhaseStep: lfo_step <= cfg_wdata;
                    RegFbGain:    fb_gain  <= cfg_wdata[15:0];
                    RegSweepLow:  d_low    <= cfg_wdata[15:0];
                    RegSweepHigh: d_high   <= cfg_wdata[15:0];
                    RegDryGain:   dry_mult <= cfg_wdata[15:0];
                    RegWetGain:   wet_mult <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                mix_queue.push_back(phaser_mix(s_axis_tdata));
            // Compare each result transaction with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                samples_checked <= samples_checked + 1;
                if (mix_queue.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("ERROR: unexpected result %0d", $signed(m_axis_tdata));
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = mix_queue.pop_front();
                    if (want !== m_axis_tdata) begin
                        if (mismatch_count < 10)
                            $display("ERROR: sample_out expected %0d got %0d",
                                     want, $signed(m_axis_tdata));
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/sv/tb_lfo_swept_allpass_phaser_unit.sv]
`timescale 1ns / 1ps
module tb_lfo_swept_allpass_phaser_unit;
    import lsap_pkg::*;

    localparam logic [CfgIdxW-1:0] RegSpare0 = 3'd6;
    localparam logic [CfgIdxW-1:0] RegSpare1 = 3'd7;
    localparam int StallLimit = 5000;
    localparam int HoldCycles = 400;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [15:0]         m_axis_tdata;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_addr;
    logic [CfgDataW-1:0] cfg_wdata;

    int  samples_pending;
    int  mismatch_count;
    int  samples_checked;
    int  samples_sent;
    int  settings_run;
    bit  steady;
    bit  hold_req;

    lfo_swept_allpass_phaser_unit i_dut (.*);

    lsap_phaser_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Offer one sample and hold it until the transaction completes
    task automatic send_sample(input logic [15:0] v);
        logic ok;
        while (!steady && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do begin
            @(negedge aclk);
            ok = s_axis_tready;
            @(posedge aclk);
        end while (!ok);
        samples_sent++;
    endtask

    // Write a register once the block has drained
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (samples_pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_samples(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) send_sample(16'($urandom_range(511)) - 16'd256);
            else                        send_sample(16'($urandom));
        end
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 6);
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= StallLimit) begin
                $display("watchdog: no transaction for %0d cycles", StallLimit);
                $display("tb_lfo_swept_allpass_phaser_unit failed");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] edges [8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001,
                                   16'hFFFF, 16'h5555, 16'hAAAA, 16'h7FFE};
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        samples_sent  = 0;
        settings_run  = 1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: directed extremes, then random content
        foreach (edges[i]) send_sample(edges[i]);
        repeat (6) send_sample(16'h7FFF);
        repeat (6) send_sample(16'h8000);
        random_samples(130);

        // Extremes: fast sweep, reversed bounds, full feedback, sign-flipped dry
        write_reg(RegPhaseStep, 31'h7FFF_FFFF);
        write_reg(RegFbGain,    {15'h7ABC, 16'h7FFF});
        write_reg(RegSweepLow,  31'h0000_FFFF);
        write_reg(RegSweepHigh, 31'h7FFF_0000);
        write_reg(RegDryGain,   31'h0000_8000);
        write_reg(RegWetGain,   31'h0000_7FFF);
        write_reg(RegSpare0,    31'h1234_5678);
        write_reg(RegSpare1,    31'h7FFF_FFFF);
        settings_run++;
        steady = 1'b1;
        foreach (edges[i]) send_sample(edges[i]);
        random_samples(140);
        steady = 1'b0;

        // Opposite extremes, frozen LFO; the receiver holds off for a while
        write_reg(RegPhaseStep, 31'h0);
        write_reg(RegFbGain,    31'h0000_8000);
        write_reg(RegSweepLow,  31'h0);
        write_reg(RegSweepHigh, 31'h0000_FFFF);
        write_reg(RegDryGain,   31'h0000_7FFF);
        write_reg(RegWetGain,   31'h5A5A_8000);
        settings_run++;
        hold_req = 1'b1;
        random_samples(150);

        // Random settings
        for (int p = 0; p < 2; p++) begin
            write_reg(RegPhaseStep, 31'($urandom));
            write_reg(RegFbGain,    31'($urandom));
            write_reg(RegSweepLow,  31'($urandom));
            write_reg(RegSweepHigh, 31'($urandom));
            write_reg(RegDryGain,   31'($urandom));
            write_reg(RegWetGain,   31'($urandom));
            settings_run++;
            random_samples(80);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (samples_pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d samples over %0d register settings, %0d results checked.",
                 samples_sent, settings_run, samples_checked);
        $display("Covered sample extremes, reversed sweep, negative gains and a long stall.");
        if (mismatch_count == 0)
            $display("tb_lfo_swept_allpass_phaser_unit passed");
        else
            $display("tb_lfo_swept_allpass_phaser_unit failed");
        $finish;
    end
endmodule
